### sv/p3lt_pkg.sv
// shared types, codes and verb table for the pop3 session line tracker
package p3lt_pkg;

  localparam int MAX_LINE_DEF = 1024;
  localparam int LEN_W        = 10;
  localparam int MASK_W       = 12;
  localparam int NUM_VERBS    = 12;

  localparam logic [3:0] VERB_UNKNOWN = 4'd12;

  // byte codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // line kinds
  localparam logic [2:0] KIND_REQUEST   = 3'd0;
  localparam logic [2:0] KIND_REPLY     = 3'd1;
  localparam logic [2:0] KIND_CONTENT   = 3'd2;
  localparam logic [2:0] KIND_END_DOT   = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;

  typedef enum logic [2:0] {
    S_INIT       = 3'd0,
    S_CMD        = 3'd1,
    S_REPLY      = 3'd2,
    S_REPLY_DATA = 3'd3,
    S_DATA       = 3'd4
  } sess_t;

  typedef enum logic [1:0] {
    PH_TOKEN = 2'd0,
    PH_SPACE = 2'd1,
    PH_ARG   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SG_NONE  = 2'd0,
    SG_PLUS  = 2'd1,
    SG_MINUS = 2'd2,
    SG_OTHER = 2'd3
  } sign_t;

  typedef struct packed {
    logic [2:0]       line_kind;
    logic             reply_ok;
    logic [3:0]       verb_code;
    logic [LEN_W-1:0] token_length;
    logic [LEN_W-1:0] arg_offset;
    logic [LEN_W-1:0] arg_length;
    logic [LEN_W-1:0] line_length;
    logic             line_too_long;
    logic             wrong_direction;
    logic [2:0]       next_state;
  } res_t;

  // verb names, upper case, first character in the low byte
  localparam logic [31:0] VERB_CHARS [NUM_VERBS] = '{
    32'h00504F54, 32'h504F5041, 32'h454C4544, 32'h5453494C,
    32'h504F4F4E, 32'h53534150, 32'h54495551, 32'h52544552,
    32'h54455352, 32'h54415453, 32'h4C444955, 32'h52455355
  };

  function automatic logic [3:0] lookup_verb(input logic [31:0] chars,
                                             input logic [LEN_W-1:0] count);
    logic [3:0]       verb;
    logic [LEN_W-1:0] want;
    verb = VERB_UNKNOWN;
    // walk downward so the lowest matching code wins
    for (int v = NUM_VERBS - 1; v >= 0; v--) begin
      want = (v == 0) ? LEN_W'(3) : LEN_W'(4);
      if (count == want && chars == VERB_CHARS[v]) begin
        verb = 4'(v);
      end
    end
    return verb;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF;
  endfunction

endpackage

### sv/pop3_session_line_tracker.sv
// top level: input register, line scanner and result register
//
// Takes a pop3 session one byte per beat on the in_ channel, each byte
// tagged with its direction (in_to_server). Bytes within a line give no
// result; an lf, or a byte from the direction the session does not
// expect, gives one result beat on the out_ channel describing the line.
// A byte accepted into the input register is scanned from there, and its
// result, if any, is loaded into the result register, which drives
// out_valid, when the scanner steps. One byte is taken per cycle unless
// a stalled result holds it back: the scanner updates its counters and
// compares in one pass.
// When the receiver stalls, the result register holds its beat; bytes
// that give no result keep flowing, and the first byte that would give a
// result waits in the input register until the result beat is taken.
// cfg_we with cfg_wdata writes the multi-line verb mask;
// write it only while the block is idle.
// Synchronous active-low reset returns the session to its init state,
// empties both registers and sets the mask to select RETR.
module pop3_session_line_tracker #(
  parameter int MAX_LINE = p3lt_pkg::MAX_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_to_server,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_line_kind,
  output logic                        out_reply_ok,
  output logic [3:0]                  out_verb_code,
  output logic [p3lt_pkg::LEN_W-1:0]  out_token_length,
  output logic [p3lt_pkg::LEN_W-1:0]  out_arg_offset,
  output logic [p3lt_pkg::LEN_W-1:0]  out_arg_length,
  output logic [p3lt_pkg::LEN_W-1:0]  out_line_length,
  output logic                        out_line_too_long,
  output logic                        out_wrong_direction,
  output logic [2:0]                  out_next_state,
  input  logic                        cfg_we,
  input  logic [p3lt_pkg::MASK_W-1:0] cfg_wdata
);
  import p3lt_pkg::*;

  localparam logic [MASK_W-1:0] MaskReset = MASK_W'(128);

  logic              in_vld_r;
  logic [7:0]        byte_r;
  logic              dir_r;
  logic [MASK_W-1:0] mask_r;
  logic              out_vld_r;
  res_t              res_r;
  logic              step, has_res, in_take, out_load;
  res_t              res;

  // beat moves through the scanner unless its result has nowhere to go
  assign step     = in_vld_r && (!has_res || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;
  assign in_take  = in_valid && in_ready;
  assign out_load = step && has_res;

  p3lt_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (byte_r),
    .to_server (dir_r),
    .mask      (mask_r),
    .has_res   (has_res),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_data_byte;
      dir_r  <= in_to_server;
    end
  end

  // multi-line verb mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MaskReset;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_line_kind       = res_r.line_kind;
  assign out_reply_ok        = res_r.reply_ok;
  assign out_verb_code       = res_r.verb_code;
  assign out_token_length    = res_r.token_length;
  assign out_arg_offset      = res_r.arg_offset;
  assign out_arg_length      = res_r.arg_length;
  assign out_line_length     = res_r.line_length;
  assign out_line_too_long   = res_r.line_too_long;
  assign out_wrong_direction = res_r.wrong_direction;
  assign out_next_state      = res_r.next_state;

endmodule

### sv/p3lt_scan.sv
// session state, line scan registers and per-beat result logic
module p3lt_scan #(
  parameter int MAX_LINE = p3lt_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic                          to_server,
  input  logic [p3lt_pkg::MASK_W-1:0]   mask,
  output logic                          has_res,
  output p3lt_pkg::res_t                res
);
  import p3lt_pkg::*;

  localparam int CapRaw = (MAX_LINE - 1) < 1023 ? (MAX_LINE - 1) : 1023;
  localparam logic [LEN_W-1:0] LineCap = LEN_W'(CapRaw);

  sess_t            state_r, state_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [31:0]      chars_r, chars_nxt;
  logic [LEN_W-1:0] tok_r, tok_nxt;
  logic [LEN_W-1:0] arg_r, arg_nxt;
  logic             ended_r, ended_nxt;
  sign_t            sign_r, sign_nxt;
  logic             long_r, long_nxt;

  logic             wrong, is_lf, reply, sp, pos0;
  logic [7:0]       upper;
  logic [3:0]       verb;
  logic [15:0]      mask_pad;
  logic [LEN_W-1:0] off;
  sess_t            next_st;

  // decode of the current beat
  always_comb begin
    wrong    = to_server != (state_r == S_CMD);
    is_lf    = data_byte == CH_LF;
    has_res  = wrong || is_lf;
    reply    = state_r != S_CMD;
    sp       = is_space(data_byte);
    pos0     = pos_r == '0;
    upper    = (data_byte >= 8'h61 && data_byte <= 8'h7A) ? data_byte - 8'h20 : data_byte;
    verb     = lookup_verb(chars_r, tok_r);
    mask_pad = {{(16 - MASK_W){1'b0}}, mask};
    off      = (phase_r == PH_ARG) ? arg_r : pos_r;
  end

  // result of a line end or a misdirected beat
  always_comb begin
    res           = '0;
    next_st       = state_r;
    res.verb_code = VERB_UNKNOWN;
    if (wrong) begin
      res.verb_code       = 4'd0;
      res.wrong_direction = 1'b1;
    end else begin
      res.line_length   = pos_r;
      res.line_too_long = long_r;
      unique case (state_r)
        S_CMD: begin
          res.line_kind    = KIND_REQUEST;
          res.verb_code    = verb;
          res.token_length = tok_r;
          res.arg_offset   = off;
          res.arg_length   = pos_r - off;
          next_st = (verb != VERB_UNKNOWN && mask_pad[verb]) ? S_REPLY_DATA : S_REPLY;
        end
        S_DATA: begin
          if (pos_r == LEN_W'(1) && sign_r == SG_PLUS) begin
            res.line_kind = KIND_END_DOT;
            next_st       = S_CMD;
          end else begin
            res.line_kind = KIND_CONTENT;
            next_st       = S_DATA;
          end
        end
        default: begin
          if (!pos0 && (sign_r == SG_PLUS || sign_r == SG_MINUS)) begin
            res.line_kind    = KIND_REPLY;
            res.reply_ok     = sign_r == SG_PLUS;
            res.token_length = tok_r;
            res.arg_offset   = off;
            res.arg_length   = pos_r - off;
            next_st = (state_r == S_REPLY_DATA && sign_r == SG_PLUS) ? S_DATA : S_CMD;
          end else begin
            res.line_kind = KIND_MALFORMED;
          end
        end
      endcase
    end
    res.next_state = next_st;
  end

  // state update for an accepted beat
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    chars_nxt = chars_r;
    tok_nxt   = tok_r;
    arg_nxt   = arg_r;
    ended_nxt = ended_r;
    sign_nxt  = sign_r;
    long_nxt  = long_r;
    if (step && !wrong) begin
      if (is_lf) begin
        state_nxt = next_st;
        pos_nxt   = '0;
        phase_nxt = PH_TOKEN;
        chars_nxt = '0;
        tok_nxt   = '0;
        arg_nxt   = '0;
        ended_nxt = 1'b0;
        sign_nxt  = SG_NONE;
        long_nxt  = 1'b0;
      end else if (ended_r) begin
        // bytes after cr wait for lf
      end else if (data_byte == CH_CR) begin
        ended_nxt = 1'b1;
      end else if (pos_r >= LineCap) begin
        long_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + LEN_W'(1);
        if (state_r == S_DATA) begin
          if (pos0) begin
            sign_nxt = (data_byte == CH_DOT) ? SG_PLUS : SG_OTHER;
          end
        end else begin
          if (reply && pos0) begin
            sign_nxt = (data_byte == CH_PLUS)  ? SG_PLUS :
                       (data_byte == CH_MINUS) ? SG_MINUS : SG_OTHER;
          end
          unique case (phase_r)
            PH_TOKEN: begin
              if (!sp || (reply && pos0)) begin
                if (tok_r < LEN_W'(4)) begin
                  chars_nxt[{tok_r[1:0], 3'b000} +: 8] = upper;
                end
                tok_nxt = tok_r + LEN_W'(1);
              end else begin
                phase_nxt = PH_SPACE;
              end
            end
            PH_SPACE: begin
              if (!sp) begin
                arg_nxt   = pos_r;
                phase_nxt = PH_ARG;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pos_r   <= '0;
      phase_r <= PH_TOKEN;
      chars_r <= '0;
      tok_r   <= '0;
      arg_r   <= '0;
      ended_r <= 1'b0;
      sign_r  <= SG_NONE;
      long_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      chars_r <= chars_nxt;
      tok_r   <= tok_nxt;
      arg_r   <= arg_nxt;
      ended_r <= ended_nxt;
      sign_r  <= sign_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

### tb/p3lt_tb_pkg.sv
// verb codes and the line-result scoreboard used by the session tracker testbench
package p3lt_tb_pkg;
  import p3lt_pkg::*;

  typedef enum logic [3:0] {
    V_TOP     = 4'd0,
    V_APOP    = 4'd1,
    V_DELE    = 4'd2,
    V_LIST    = 4'd3,
    V_NOOP    = 4'd4,
    V_PASS    = 4'd5,
    V_QUIT    = 4'd6,
    V_RETR    = 4'd7,
    V_RSET    = 4'd8,
    V_STAT    = 4'd9,
    V_UIDL    = 4'd10,
    V_USER    = 4'd11,
    V_UNKNOWN = 4'd12
  } verb_e;

  function automatic string verb_name(verb_e v);
    case (v)
      V_TOP:   return "TOP";
      V_APOP:  return "APOP";
      V_DELE:  return "DELE";
      V_LIST:  return "LIST";
      V_NOOP:  return "NOOP";
      V_PASS:  return "PASS";
      V_QUIT:  return "QUIT";
      V_RETR:  return "RETR";
      V_RSET:  return "RSET";
      V_STAT:  return "STAT";
      V_UIDL:  return "UIDL";
      V_USER:  return "USER";
      default: return "";
    endcase
  endfunction

  class line_result_board;
    int               line_cap;
    logic [MASK_W-1:0] data_verbs;
    sess_t            state;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] tok_cnt;
    logic [LEN_W-1:0] arg_at;
    phase_t           phase;
    logic [31:0]      lead_chars;
    logic             cr_seen;
    logic             over_cap;
    sign_t            sign;
    res_t             expected_lines[$];
    int unsigned      mismatches;

    function new(int max_line);
      line_cap   = (max_line - 1 < 1023) ? max_line - 1 : 1023;
      data_verbs = 12'd1 << V_RETR;
      state      = S_INIT;
      mismatches = 0;
      clear_line();
    endfunction

    function void set_data_verbs(logic [MASK_W-1:0] m);
      data_verbs = m;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void clear_line();
      pos        = '0;
      tok_cnt    = '0;
      arg_at     = '0;
      phase      = PH_TOKEN;
      lead_chars = '0;
      cr_seen    = 1'b0;
      over_cap   = 1'b0;
      sign       = SG_NONE;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF;
    endfunction

    // first token against the verb table, case already folded
    function verb_e match_verb();
      string nm;
      bit    same;
      for (int v = 0; v < NUM_VERBS; v++) begin
        nm   = verb_name(verb_e'(v));
        same = (tok_cnt == nm.len());
        for (int i = 0; same && i < nm.len(); i++) begin
          if (lead_chars[8*i +: 8] != nm[i]) same = 1'b0;
        end
        if (same) return verb_e'(v);
      end
      return V_UNKNOWN;
    endfunction

    // one content byte of the current line
    function void scan(logic [7:0] b);
      logic       reply;
      logic       sp;
      logic [7:0] up;
      reply = (state != S_CMD);
      sp    = is_blank(b);
      if (state == S_DATA) begin
        if (pos == 0) sign = (b == CH_DOT) ? SG_PLUS : SG_OTHER;
        return;
      end
      if (reply && pos == 0) begin
        sign = (b == CH_PLUS) ? SG_PLUS : (b == CH_MINUS) ? SG_MINUS : SG_OTHER;
      end
      case (phase)
        PH_TOKEN: begin
          // a reply's first byte always joins the token
          if (!sp || (reply && pos == 0)) begin
            if (tok_cnt < 4) begin
              up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
              lead_chars[8*tok_cnt +: 8] = up;
            end
            tok_cnt++;
          end else begin
            phase = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (!sp) begin
            arg_at = pos;
            phase  = PH_ARG;
          end
        end
        default: ;
      endcase
    endfunction

    // accepted input beat: update the session and queue any line result
    function void accept_byte(logic [7:0] b, logic ts);
      res_t             r;
      logic [LEN_W-1:0] off;
      verb_e            verb;
      r = '0;
      if (ts != (state == S_CMD)) begin
        r.wrong_direction = 1'b1;
        r.next_state      = state;
        expected_lines.push_back(r);
        return;
      end
      if (b != CH_LF) begin
        if (cr_seen) return;
        if (b == CH_CR) begin
          cr_seen = 1'b1;
          return;
        end
        if (pos >= line_cap) begin
          over_cap = 1'b1;
          return;
        end
        scan(b);
        pos++;
        return;
      end
      // end of line
      r.verb_code     = V_UNKNOWN;
      r.next_state    = state;
      r.line_length   = pos;
      r.line_too_long = over_cap;
      off = (phase == PH_ARG) ? arg_at : pos;
      if (state == S_CMD) begin
        verb           = match_verb();
        r.line_kind    = KIND_REQUEST;
        r.verb_code    = verb;
        r.token_length = tok_cnt;
        r.arg_offset   = off;
        r.arg_length   = pos - off;
        r.next_state   = (verb != V_UNKNOWN && data_verbs[verb]) ? S_REPLY_DATA : S_REPLY;
      end else if (state == S_DATA) begin
        if (pos == 1 && sign == SG_PLUS) begin
          r.line_kind  = KIND_END_DOT;
          r.next_state = S_CMD;
        end else begin
          r.line_kind  = KIND_CONTENT;
          r.next_state = S_DATA;
        end
      end else if (pos > 0 && (sign == SG_PLUS || sign == SG_MINUS)) begin
        r.line_kind    = KIND_REPLY;
        r.reply_ok     = (sign == SG_PLUS);
        r.token_length = tok_cnt;
        r.arg_offset   = off;
        r.arg_length   = pos - off;
        r.next_state   = (state == S_REPLY_DATA && r.reply_ok) ? S_DATA : S_CMD;
      end else begin
        r.line_kind = KIND_MALFORMED;
      end
      expected_lines.push_back(r);
      state = sess_t'(r.next_state);
      clear_line();
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
    endtask

    // accepted result beat against the oldest expected line
    task match_result(res_t got);
      res_t want;
      if (expected_lines.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
        return;
      end
      want = expected_lines.pop_front();
      cmp_field("line_kind", 32'(got.line_kind), 32'(want.line_kind));
      cmp_field("reply_ok", 32'(got.reply_ok), 32'(want.reply_ok));
      cmp_field("verb_code", 32'(got.verb_code), 32'(want.verb_code));
      cmp_field("token_length", 32'(got.token_length), 32'(want.token_length));
      cmp_field("arg_offset", 32'(got.arg_offset), 32'(want.arg_offset));
      cmp_field("arg_length", 32'(got.arg_length), 32'(want.arg_length));
      cmp_field("line_length", 32'(got.line_length), 32'(want.line_length));
      cmp_field("line_too_long", 32'(got.line_too_long), 32'(want.line_too_long));
      cmp_field("wrong_direction", 32'(got.wrong_direction), 32'(want.wrong_direction));
      cmp_field("next_state", 32'(got.next_state), 32'(want.next_state));
    endtask

    task close_out();
      if (expected_lines.size() != 0) begin
        flag_mismatch($sformatf("%0d expected results never came", expected_lines.size()));
      end
    endtask
  endclass

endpackage

### tb/pop3_session_line_tracker_test.sv
// testbench top: drives pop3 session bytes and checks every line result
module pop3_session_line_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import p3lt_pkg::*;
  import p3lt_tb_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int MAX_LINE      = MAX_LINE_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 200000;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = '0;
  logic              in_to_server = 1'b0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [2:0]        out_line_kind;
  logic              out_reply_ok;
  logic [3:0]        out_verb_code;
  logic [LEN_W-1:0]  out_token_length;
  logic [LEN_W-1:0]  out_arg_offset;
  logic [LEN_W-1:0]  out_arg_length;
  logic [LEN_W-1:0]  out_line_length;
  logic              out_line_too_long;
  logic              out_wrong_direction;
  logic [2:0]        out_next_state;
  logic              cfg_we       = 1'b0;
  logic [MASK_W-1:0] cfg_wdata    = '0;

  line_result_board sb;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      byte_count     = 0;
  bit               hold_go        = 1'b0;
  logic             holding        = 1'b0;

  pop3_session_line_tracker #(
    .MAX_LINE(MAX_LINE)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_to_server       (in_to_server),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_kind      (out_line_kind),
    .out_reply_ok       (out_reply_ok),
    .out_verb_code      (out_verb_code),
    .out_token_length   (out_token_length),
    .out_arg_offset     (out_arg_offset),
    .out_arg_length     (out_arg_length),
    .out_line_length    (out_line_length),
    .out_line_too_long  (out_line_too_long),
    .out_wrong_direction(out_wrong_direction),
    .out_next_state     (out_next_state),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic res_t got_beat();
    res_t r;
    r.line_kind       = out_line_kind;
    r.reply_ok        = out_reply_ok;
    r.verb_code       = out_verb_code;
    r.token_length    = out_token_length;
    r.arg_offset      = out_arg_offset;
    r.arg_length      = out_arg_length;
    r.line_length     = out_line_length;
    r.line_too_long   = out_line_too_long;
    r.wrong_direction = out_wrong_direction;
    r.next_state      = out_next_state;
    return r;
  endfunction

  // result side: check accepted beats, stall at random or during the hold
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_result(got_beat());
    out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic set_pace(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // one input beat, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_to_server <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_byte(b, ts);
    byte_count++;
  endtask

  // wait until every expected line has come and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    sb.set_data_verbs(m);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(9) == 0) return blank_byte();
    do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  // line text with an occasional beat from the other side mixed in
  task automatic send_text(int n, logic ts);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_byte(text_byte(), !ts);
      send_byte(text_byte(), ts);
    end
  endtask

  task automatic send_word(string s, logic ts, bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
      send_byte(c, ts);
    end
  endtask

  // crlf, bare lf, or cr followed by junk that must be ignored
  task automatic send_eol(logic ts);
    int unsigned k;
    k = $urandom_range(9);
    if (k < 6) begin
      send_byte(CH_CR, ts);
    end else if (k == 9) begin
      send_byte(CH_CR, ts);
      send_text($urandom_range(1, 3), ts);
    end
    send_byte(CH_LF, ts);
  endtask

  task automatic send_request();
    string       tok;
    string       junk;
    int unsigned k;
    k   = $urandom_range(19);
    tok = verb_name(verb_e'($urandom_range(NUM_VERBS - 1)));
    if (k == 15) begin
      tok = tok.substr(0, $urandom_range(0, tok.len() - 2));
    end else if (k == 16) begin
      junk = "";
      repeat ($urandom_range(1, 6)) junk = {junk, string'(8'($urandom_range(65, 90)))};
      tok = junk;
    end else if (k == 17) begin
      tok = {tok, "S"};
    end else if (k >= 18) begin
      tok = "";
    end
    send_word(tok, 1'b1, 1'b1);
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(0, 2)) send_byte(blank_byte(), 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(blank_byte(), 1'b1);
      send_text($urandom_range(1, 12), 1'b1);
    end
    send_eol(1'b1);
  endtask

  task automatic send_reply();
    int unsigned k;
    logic [7:0]  b;
    k = $urandom_range(19);
    if (k < 16) begin
      send_byte((k < 10) ? CH_PLUS : CH_MINUS, 1'b0);
      if ($urandom_range(3) == 0) send_byte(blank_byte(), 1'b0);
      if ($urandom_range(1)) send_word((k < 10) ? "OK" : "ERR", 1'b0, 1'b1);
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 2)) send_byte(blank_byte(), 1'b0);
        send_text($urandom_range(1, 15), 1'b0);
      end
    end else if (k < 18) begin
      // first byte neither plus nor minus
      do b = text_byte(); while (b == CH_PLUS || b == CH_MINUS);
      send_byte(b, 1'b0);
      send_text($urandom_range(0, 8), 1'b0);
    end
    send_eol(1'b0);
  endtask

  task automatic send_content();
    int unsigned k;
    k = $urandom_range(19);
    if (k < 5) begin
      send_byte(CH_DOT, 1'b0);
    end else if (k < 7) begin
      send_byte(CH_DOT, 1'b0);
      send_text($urandom_range(1, 6), 1'b0);
    end else if (k > 7) begin
      send_text($urandom_range(1, 20), 1'b0);
    end
    send_eol(1'b0);
  endtask

  // one line suited to the session state, or a stray beat
  task automatic send_line();
    if ($urandom_range(99) < 5) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      case (sb.state)
        S_CMD:   send_request();
        S_DATA:  send_content();
        default: send_reply();
      endcase
    end
  endtask

  task automatic send_lines(int unsigned n);
    int unsigned start;
    start = byte_count;
    while (byte_count - start < n) send_line();
  endtask

  // line of n content bytes, mostly blanks, ending in a short argument
  task automatic send_long(int n);
    sess_t st;
    logic  ts;
    int    first;
    st = sb.state;
    ts = (st == S_CMD);
    if (st == S_CMD) begin
      send_word("LIST", ts, 1'b0);
      first = 4;
    end else if (st != S_DATA) begin
      send_byte(CH_PLUS, ts);
      first = 1;
    end else begin
      first = 0;
    end
    for (int i = first; i < n; i++) send_byte((i < n - 4) ? CH_SP : text_byte(), ts);
    send_eol(ts);
  endtask

  initial begin : stimulus
    sb = new(MAX_LINE);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset mask, no idling, directed lines first
    set_pace(0, 0);
    send_byte("A", 1'b1);
    send_byte(CH_LF, 1'b0);
    send_word("+\n", 1'b0, 1'b0);
    send_word("retr 7\r\n", 1'b1, 1'b0);
    send_word("+\n", 1'b0, 1'b0);
    send_word(".\n", 1'b0, 1'b0);
    send_word("Top \n", 1'b1, 1'b0);
    send_byte(CH_MINUS, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_lines(130);

    // no verb leads to data, sender idles
    write_mask('0);
    set_pace(46, 0);
    send_lines(130);

    // every verb leads to data, receiver stalls
    write_mask('1);
    set_pace(0, 46);
    send_lines(130);

    // random mask, both sides idle a little
    write_mask(MASK_W'($urandom_range(4095)));
    set_pace(10, 10);
    send_lines(130);

    // receiver holds off while the sender keeps offering beats
    write_mask(MASK_W'(1) << V_RETR);
    set_pace(0, 0);
    hold_go = 1'b1;
    send_lines(120);

    // longest line: one byte past the cap
    set_pace(10, 10);
    send_long(1024);

    settle();
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
